FILE: rtl/core/krc_pkg.sv
// ----------------------------------------------------------------------------
// Key repeat package
// Shared widths, codes and payload types of the key repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package krc_pkg;

   // Ring buffer geometry
   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   // Payload widths
   localparam int FUNC_W  = 2;
   localparam int CODE_W  = 7;
   localparam int CHAR_W  = 8;
   localparam int FRAME_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Register reset values
   localparam logic [FRAME_W-1:0] REPEAT_DELAY_RST    = FRAME_W'(25);
   localparam logic [FRAME_W-1:0] REPEAT_INTERVAL_RST = FRAME_W'(2);

   // Item function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PRESS   = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_TICK    = 2'd2,
      FUNC_READ    = 2'd3
   } func_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REPEAT_DELAY    = 2'd0,
      CSR_REPEAT_INTERVAL = 2'd1,
      CSR_INPUT_ENABLE    = 2'd2
   } csr_idx_type;

   // One input item
   typedef struct packed {
      func_type            func;
      logic [CODE_W-1:0]   key_code;
      logic [CHAR_W-1:0]   key_char;
   } item_type;

   // One result item
   typedef struct packed {
      logic [CHAR_W-1:0]   read_char;
      logic                char_pushed;
      logic                buffer_empty;
   } result_type;

   // Settings seen by the repeat controller
   typedef struct packed {
      logic [FRAME_W-1:0]  repeat_delay;
      logic [FRAME_W-1:0]  repeat_interval;
      logic                input_enable;
      logic                cancel_hold;
   } rep_ctrl_type;

   // Push request toward the ring buffer
   typedef struct packed {
      logic                valid;
      logic [CHAR_W-1:0]   char_val;
   } push_type;

endpackage

`default_nettype wire

FILE: rtl/core/krc_ifs.sv
// ----------------------------------------------------------------------------
// Key repeat channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Input item channel
interface krc_req_if;
   logic                          valid;
   logic                          ready;
   logic [krc_pkg::FUNC_W-1:0]    func;
   logic [krc_pkg::CODE_W-1:0]    key_code;
   logic [krc_pkg::CHAR_W-1:0]    key_char;

   modport source (output valid, output func, output key_code, output key_char,
                   input ready);
   modport sink   (input valid, input func, input key_code, input key_char,
                   output ready);
endinterface

// Result channel
interface krc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [krc_pkg::CHAR_W-1:0]    read_char;
   logic                          char_pushed;
   logic                          buffer_empty;

   modport source (output valid, output read_char, output char_pushed,
                   output buffer_empty, input ready);
   modport sink   (input valid, input read_char, input char_pushed,
                   input buffer_empty, output ready);
endinterface

// Register write channel
interface krc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [krc_pkg::CSR_IDX_W-1:0]     index;
   logic [krc_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/krc_typematic.sv
// ----------------------------------------------------------------------------
// Key repeat controller
// Tracks the held key and its frame timer, and requests character pushes.
// ----------------------------------------------------------------------------
`default_nettype none

module krc_typematic (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     item_valid,
   input  krc_pkg::item_type       item,
   input  krc_pkg::rep_ctrl_type   ctrl,
   output krc_pkg::push_type       push
);

   typedef enum logic [2:0] {
      HOLD_NONE   = 3'b001,
      HOLD_DELAY  = 3'b010,
      HOLD_REPEAT = 3'b100
   } hold_type;

   hold_type                          hold_mode_ff,   hold_mode_in;
   logic [krc_pkg::CODE_W-1:0]        held_code_ff,   held_code_in;
   logic [krc_pkg::CHAR_W-1:0]        held_char_ff,   held_char_in;
   logic [krc_pkg::FRAME_W-1:0]       frames_left_ff, frames_left_in;
   logic                              holding;

   assign holding = (hold_mode_ff == HOLD_DELAY) || (hold_mode_ff == HOLD_REPEAT);

   // Next hold state and push request for the current item.
   always_comb begin
      hold_mode_in   = hold_mode_ff;
      held_code_in   = held_code_ff;
      held_char_in   = held_char_ff;
      frames_left_in = frames_left_ff;
      push.valid     = 1'b0;
      push.char_val  = item.key_char;

      if (item_valid) begin
         case (item.func)
            krc_pkg::FUNC_PRESS: begin
               if (ctrl.input_enable && (item.key_char != '0)) begin
                  frames_left_in = ctrl.repeat_delay;
                  held_code_in   = item.key_code;
                  held_char_in   = item.key_char;
                  hold_mode_in   = HOLD_DELAY;
                  push.valid     = 1'b1;
               end
            end
            krc_pkg::FUNC_RELEASE: begin
               if (held_code_ff == item.key_code) begin
                  hold_mode_in = HOLD_NONE;
               end
            end
            krc_pkg::FUNC_TICK: begin
               if (ctrl.input_enable && holding) begin
                  if (frames_left_ff <= krc_pkg::FRAME_W'(1)) begin
                     frames_left_in = ctrl.repeat_interval;
                     if (hold_mode_ff == HOLD_DELAY) begin
                        hold_mode_in = HOLD_REPEAT;
                     end else begin
                        push.valid    = 1'b1;
                        push.char_val = held_char_ff;
                     end
                  end else begin
                     frames_left_in = frames_left_ff - krc_pkg::FRAME_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // Disabling input drops any hold in progress.
      if (ctrl.cancel_hold) begin
         hold_mode_in = HOLD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_mode_ff   <= HOLD_NONE;
         held_code_ff   <= '0;
         held_char_ff   <= '0;
         frames_left_ff <= '0;
      end else begin
         hold_mode_ff   <= hold_mode_in;
         held_code_ff   <= held_code_in;
         held_char_ff   <= held_char_in;
         frames_left_ff <= frames_left_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/krc_char_fifo.sv
// ----------------------------------------------------------------------------
// Key repeat character ring buffer
// Register file with write and read positions; a push never checks for full.
// ----------------------------------------------------------------------------
`default_nettype none

module krc_char_fifo (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          clear,
   input  krc_pkg::push_type            push,
   input  wire                          pop_req,
   output logic [krc_pkg::CHAR_W-1:0]   read_char,
   output logic                         empty_next
);

   localparam logic [krc_pkg::PTR_W-1:0] LAST_POS = krc_pkg::PTR_W'(krc_pkg::FIFO_DEPTH - 1);

   logic [krc_pkg::CHAR_W-1:0]  char_store_ff [krc_pkg::FIFO_DEPTH];
   logic [krc_pkg::PTR_W-1:0]   write_pos_ff, write_pos_in;
   logic [krc_pkg::PTR_W-1:0]   read_pos_ff,  read_pos_in;
   logic                        pop;

   // A read only pops when the buffer holds something.
   assign pop       = pop_req && (write_pos_ff != read_pos_ff);
   assign read_char = pop ? char_store_ff[read_pos_ff] : '0;

   // Position advance with wrap at the buffer depth.
   always_comb begin
      write_pos_in = write_pos_ff;
      read_pos_in  = read_pos_ff;
      if (push.valid) begin
         write_pos_in = (write_pos_ff == LAST_POS) ? '0 : write_pos_ff + krc_pkg::PTR_W'(1);
      end
      if (pop) begin
         read_pos_in = (read_pos_ff == LAST_POS) ? '0 : read_pos_ff + krc_pkg::PTR_W'(1);
      end
      if (clear) begin
         write_pos_in = '0;
         read_pos_in  = '0;
      end
   end

   assign empty_next = (write_pos_in == read_pos_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff <= '0;
         read_pos_ff  <= '0;
      end else begin
         write_pos_ff <= write_pos_in;
         read_pos_ff  <= read_pos_in;
      end
   end

   // Character storage, no reset.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         char_store_ff[write_pos_ff] <= push.char_val;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/krc_rsp_skid.sv
// ----------------------------------------------------------------------------
// Key repeat result buffer
// Output register with a skid stage; the input side waits only while both
// stages hold a result.
// ----------------------------------------------------------------------------
`default_nettype none

module krc_rsp_skid (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   input  krc_pkg::result_type    in_data,
   output logic                   in_ready,
   krc_rsp_if.source              rsp
);

   logic                  out_valid_ff,  out_valid_in;
   krc_pkg::result_type   out_data_ff,   out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   krc_pkg::result_type   skid_data_ff,  skid_data_in;
   logic                  out_fire;

   assign in_ready = !skid_valid_ff;
   assign out_fire = out_valid_ff && rsp.ready;

   assign rsp.valid        = out_valid_ff;
   assign rsp.read_char    = out_data_ff.read_char;
   assign rsp.char_pushed  = out_data_ff.char_pushed;
   assign rsp.buffer_empty = out_data_ff.buffer_empty;

   // Fill the output register first, park in the skid stage when it stalls.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_fire) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (out_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/key_repeat_with_char_fifo.sv
// Each result is held in the output or skid register of the result buffer.
// Throughput: one item per cycle while req is ready; timer and ring buffer
// update in the transfer cycle; a two-entry result buffer absorbs rsp stalls.
// Reset: synchronous, active high; clears hold state, buffer positions and
// registers (delay 25, interval 2, input disabled). Buffer contents persist.
// ----------------------------------------------------------------------------
// Key repeat with character buffer
// Typematic key repeat feeding a 16-entry character ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module key_repeat_with_char_fifo (
   input  wire          clock,
   input  wire          reset,
   krc_req_if.sink      req,
   krc_rsp_if.source    rsp,
   krc_csr_if.sink      csr
);

   logic [krc_pkg::FRAME_W-1:0]   repeat_delay_ff,    repeat_delay_in;
   logic [krc_pkg::FRAME_W-1:0]   repeat_interval_ff, repeat_interval_in;
   logic                          input_enable_ff,    input_enable_in;
   logic                          csr_fire;
   logic                          buf_clear;
   logic                          item_fire;
   krc_pkg::item_type             item;
   krc_pkg::rep_ctrl_type         ctrl;
   krc_pkg::push_type             push;
   krc_pkg::result_type           result;
   logic                          pop_req;

   // Register writes are always taken.
   assign csr.ready = 1'b1;
   assign csr_fire  = csr.valid && csr.ready;

   always_comb begin
      repeat_delay_in    = repeat_delay_ff;
      repeat_interval_in = repeat_interval_ff;
      input_enable_in    = input_enable_ff;
      buf_clear          = 1'b0;
      ctrl.cancel_hold   = 1'b0;
      if (csr_fire) begin
         case (krc_pkg::csr_idx_type'(csr.index))
            krc_pkg::CSR_REPEAT_DELAY:    repeat_delay_in    = csr.data;
            krc_pkg::CSR_REPEAT_INTERVAL: repeat_interval_in = csr.data;
            krc_pkg::CSR_INPUT_ENABLE: begin
               input_enable_in  = csr.data[0];
               buf_clear        = csr.data[0];
               ctrl.cancel_hold = !csr.data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_delay_ff    <= krc_pkg::REPEAT_DELAY_RST;
         repeat_interval_ff <= krc_pkg::REPEAT_INTERVAL_RST;
         input_enable_ff    <= 1'b0;
      end else begin
         repeat_delay_ff    <= repeat_delay_in;
         repeat_interval_ff <= repeat_interval_in;
         input_enable_ff    <= input_enable_in;
      end
   end

   assign ctrl.repeat_delay    = repeat_delay_ff;
   assign ctrl.repeat_interval = repeat_interval_ff;
   assign ctrl.input_enable    = input_enable_ff;

   // Item transfer.
   assign item_fire     = req.valid && req.ready;
   assign item.func     = krc_pkg::func_type'(req.func);
   assign item.key_code = req.key_code;
   assign item.key_char = req.key_char;
   assign pop_req       = item_fire && (item.func == krc_pkg::FUNC_READ);

   krc_typematic u_typematic (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_fire),
      .item       (item),
      .ctrl       (ctrl),
      .push       (push)
   );

   krc_char_fifo u_char_fifo (
      .clock      (clock),
      .reset      (reset),
      .clear      (buf_clear),
      .push       (push),
      .pop_req    (pop_req),
      .read_char  (result.read_char),
      .empty_next (result.buffer_empty)
   );

   assign result.char_pushed = push.valid;

   krc_rsp_skid u_rsp_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (item_fire),
      .in_data  (result),
      .in_ready (req.ready),
      .rsp      (rsp)
   );

`ifndef SYNTHESIS
   // A single item never both pushes and pops.
   a_push_pop_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && pop_req))
      else $error("push and pop on the same item");

   // Every transferred item has a result ready in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      item_fire |=> rsp.valid)
      else $error("no result after item transfer");

   // Backpressure on req only while a result is waiting.
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid)
      else $error("req stalled with no pending result");

   // A character is pushed only while input is enabled.
   a_push_enabled: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> input_enable_ff)
      else $error("push while input disabled");
`endif

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key repeat with character buffer testbench
// Drives key presses, releases, frame ticks and reads into the block under
// random sender bursts and receiver stalls, across several repeat settings.
// A tracker class predicts each result and compares it field by field.
// ----------------------------------------------------------------------------

module testbench;
   import krc_pkg::*;

   // Register index with no register behind it; writes to it are dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 2'd3;

   // Hold state of the repeat timer
   typedef enum logic [1:0] {
      HOLD_NONE   = 2'd0,
      HOLD_DELAY  = 2'd1,
      HOLD_REPEAT = 2'd2
   } hold_state_type;

   // Tracks the typematic state and ring buffer, and holds the results that
   // the block still owes in transfer order.
   class keyrep_tracker;
      hold_state_type      hold_mode;
      logic [CODE_W-1:0]   held_code;
      logic [CHAR_W-1:0]   held_char;
      logic [FRAME_W-1:0]  frames_left;
      logic [CHAR_W-1:0]   char_store [FIFO_DEPTH];
      logic [PTR_W-1:0]    write_pos;
      logic [PTR_W-1:0]    read_pos;
      logic [FRAME_W-1:0]  repeat_delay;
      logic [FRAME_W-1:0]  repeat_interval;
      logic                input_enable;
      result_type          awaited_results[$];
      int                  mismatches;

      function new();
         hold_mode       = HOLD_NONE;
         held_code       = '0;
         held_char       = '0;
         frames_left     = '0;
         write_pos       = '0;
         read_pos        = '0;
         repeat_delay    = REPEAT_DELAY_RST;
         repeat_interval = REPEAT_INTERVAL_RST;
         input_enable    = 1'b0;
         mismatches      = 0;
         foreach (char_store[i]) char_store[i] = '0;
      endfunction

      function logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p);
         return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
      endfunction

      // Register write transfer; only issued while the block is idle.
      function void apply_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_REPEAT_DELAY: begin
               repeat_delay = value;
            end
            CSR_REPEAT_INTERVAL: begin
               repeat_interval = value;
            end
            CSR_INPUT_ENABLE: begin
               if (value[0]) begin
                  write_pos    = '0;
                  read_pos     = '0;
                  input_enable = 1'b1;
               end else begin
                  input_enable = 1'b0;
                  hold_mode    = HOLD_NONE;
               end
            end
            default: ;
         endcase
      endfunction

      // Works out the result of one accepted item and queues it.
      function void note_item(item_type it);
         result_type r;
         r = '0;
         case (it.func)
            FUNC_PRESS: begin
               if (input_enable && it.key_char != '0) begin
                  frames_left = repeat_delay;
                  held_code   = it.key_code;
                  held_char   = it.key_char;
                  hold_mode   = HOLD_DELAY;
                  char_store[write_pos] = it.key_char;
                  write_pos   = next_slot(write_pos);
                  r.char_pushed = 1'b1;
               end
            end
            FUNC_RELEASE: begin
               if (held_code == it.key_code) hold_mode = HOLD_NONE;
            end
            FUNC_TICK: begin
               if (input_enable && (hold_mode == HOLD_DELAY || hold_mode == HOLD_REPEAT)) begin
                  if (frames_left <= 1) begin
                     frames_left = repeat_interval;
                     if (hold_mode == HOLD_DELAY) begin
                        hold_mode = HOLD_REPEAT;
                     end else begin
                        char_store[write_pos] = held_char;
                        write_pos     = next_slot(write_pos);
                        r.char_pushed = 1'b1;
                     end
                  end else begin
                     frames_left = frames_left - 1'b1;
                  end
               end
            end
            default: begin
               if (write_pos != read_pos) begin
                  r.read_char = char_store[read_pos];
                  read_pos    = next_slot(read_pos);
               end
            end
         endcase
         r.buffer_empty = (write_pos == read_pos);
         awaited_results.push_back(r);
      endfunction

      task report(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      // Compares one result transfer with the oldest awaited result.
      task check_result(result_type got);
         result_type want;
         if (awaited_results.size() == 0) begin
            report($sformatf("result with nothing awaited: char %h pushed %b empty %b",
                             got.read_char, got.char_pushed, got.buffer_empty));
            return;
         end
         want = awaited_results.pop_front();
         if (got.read_char !== want.read_char)
            report($sformatf("read_char %h, expected %h", got.read_char, want.read_char));
         if (got.char_pushed !== want.char_pushed)
            report($sformatf("char_pushed %b, expected %b", got.char_pushed, want.char_pushed));
         if (got.buffer_empty !== want.buffer_empty)
            report($sformatf("buffer_empty %b, expected %b", got.buffer_empty,
                             want.buffer_empty));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   krc_req_if req_ch ();
   krc_rsp_if rsp_ch ();
   krc_csr_if csr_ch ();

   key_repeat_with_char_fifo uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   keyrep_tracker tracker;
   int            burst_left = 1;
   logic [7:0]    ready_pattern = 8'hFF;
   int            ready_phase = 0;

   always #5 clock = ~clock;

   // Receiver stalls follow a random 8-bit ready pattern that keeps bit 0 set.
   always @(posedge clock) begin
      if (ready_phase % 32 == 0) begin
         if ($urandom_range(0, 3) == 0) ready_pattern = 8'hFF;
         else ready_pattern = 8'($urandom) | 8'h01;
      end
      rsp_ch.ready <= ready_pattern[ready_phase % 8];
      ready_phase++;
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         tracker.check_result({rsp_ch.read_char, rsp_ch.char_pushed, rsp_ch.buffer_empty});
   end

   // Ends the sender's burst when it runs out and idles for a random gap.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // One item transfer, then sender pacing.
   task automatic send_item(func_type f, logic [CODE_W-1:0] code, logic [CHAR_W-1:0] ch);
      item_type it;
      it.func     = f;
      it.key_code = code;
      it.key_char = ch;
      req_ch.valid    <= 1'b1;
      req_ch.func     <= f;
      req_ch.key_code <= code;
      req_ch.key_char <= ch;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.note_item(it);
      pace_sender();
   endtask

   // Holds the sender off until every awaited result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (tracker.awaited_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      tracker.apply_register(idx, value);
   endtask

   task automatic setup_phase(logic [FRAME_W-1:0] delay, logic [FRAME_W-1:0] interval,
                              logic enable);
      write_register(CSR_REPEAT_DELAY, delay);
      write_register(CSR_REPEAT_INTERVAL, interval);
      // Only bit 0 of the enable register matters; the rest is random.
      write_register(CSR_INPUT_ENABLE, {7'($urandom), enable});
   endtask

   // Random traffic: one press to arm the timer, then a weighted mix.
   task automatic run_phase(int count, int tick_pct, int read_pct, int press_pct);
      int                pick;
      func_type          f;
      logic [CODE_W-1:0] code;
      logic [CHAR_W-1:0] ch;
      send_item(FUNC_PRESS, 7'($urandom), 8'($urandom_range(1, 255)));
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         code = 7'($urandom);
         ch   = 8'($urandom);
         if (pick < tick_pct) begin
            f = FUNC_TICK;
         end else if (pick < tick_pct + read_pct) begin
            f = FUNC_READ;
         end else if (pick < tick_pct + read_pct + press_pct) begin
            f = FUNC_PRESS;
            if ($urandom_range(0, 9) != 0 && ch == '0) ch = 8'($urandom_range(1, 255));
         end else begin
            f = FUNC_RELEASE;
            if ($urandom_range(0, 3) != 0) code = tracker.held_code;
         end
         send_item(f, code, ch);
         // Now and then the sender waits for the block to catch up.
         if ($urandom_range(0, 149) == 0) wait_drained();
      end
   endtask

   initial begin
      tracker = new();
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.func     <= FUNC_PRESS;
      req_ch.key_code <= '0;
      req_ch.key_char <= '0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= CSR_REPEAT_DELAY;
      csr_ch.data     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Input disabled after reset: press and tick do nothing, read is empty.
      send_item(FUNC_PRESS, 7'h7F, 8'hFF);
      send_item(FUNC_TICK, 7'h00, 8'h00);
      send_item(FUNC_READ, 7'h00, 8'h00);
      send_item(FUNC_RELEASE, 7'h00, 8'h00);

      // Zero delay and interval: the first tick ends the delay, later ticks push.
      write_register(CSR_IDX_UNUSED, 8'hA5);
      setup_phase(8'd0, 8'd0, 1'b1);
      send_item(FUNC_PRESS, 7'h00, 8'h01);
      send_item(FUNC_TICK, 7'h2A, 8'hFF);
      send_item(FUNC_TICK, 7'h00, 8'h00);
      send_item(FUNC_PRESS, 7'h05, 8'h00);
      send_item(FUNC_RELEASE, 7'h55, 8'h00);
      send_item(FUNC_TICK, 7'h7F, 8'h80);
      send_item(FUNC_READ, 7'h7F, 8'hFF);
      send_item(FUNC_READ, 7'h00, 8'h00);
      send_item(FUNC_READ, 7'h00, 8'h00);
      send_item(FUNC_READ, 7'h00, 8'h00);
      send_item(FUNC_RELEASE, 7'h00, 8'h00);
      send_item(FUNC_TICK, 7'h00, 8'h00);
      send_item(FUNC_PRESS, 7'h7F, 8'h80);

      // Random phases over a spread of settings, the extremes among them.
      setup_phase(REPEAT_DELAY_RST, REPEAT_INTERVAL_RST, 1'b1);
      run_phase(300, 60, 15, 10);
      setup_phase(8'd0, 8'd0, 1'b1);
      run_phase(250, 50, 8, 20);
      setup_phase(8'd1, 8'd1, 1'b1);
      run_phase(250, 40, 30, 15);
      setup_phase(8'd255, 8'd255, 1'b1);
      run_phase(700, 97, 3, 0);
      setup_phase(8'd7, 8'd3, 1'b0);
      run_phase(150, 40, 20, 25);
      setup_phase(8'd2, 8'd5, 1'b1);
      run_phase(300, 50, 20, 15);
      setup_phase(8'($urandom_range(1, 10)), 8'($urandom_range(0, 4)), 1'b1);
      run_phase(250, 45, 25, 15);

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.awaited_results.size() != 0)
         tracker.report($sformatf("%0d results never arrived",
                                  tracker.awaited_results.size()));
      if (tracker.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Run limit
   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
